// File: hdl/likelihood_underflow_rescaler_top_macros.svh
// Assertion macros shared by the rescaler modules.
`ifndef LIKELIHOOD_UNDERFLOW_RESCALER_TOP_MACROS_SVH
`define LIKELIHOOD_UNDERFLOW_RESCALER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LUR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A signal keeps its value in the cycle after a condition holds.
`define LUR_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);
`endif

// File: hdl/lur_pkg.sv
// ----------------------------------------------------------------------------
// Likelihood rescaler package
// Shared types, constants and the per-lane scaling function.
// ----------------------------------------------------------------------------
package lur_pkg;

  localparam int unsigned Lanes = 16;
  localparam int unsigned Pairs = 8;
  localparam int unsigned IdxW = 24;
  localparam logic [30:0] TinyLimit = 31'h2F80_0000;

  typedef struct packed {
    logic [63:0] stream3_hi;
    logic [63:0] stream3_lo;
    logic [63:0] stream2_hi;
    logic [63:0] stream2_lo;
    logic [63:0] stream1_hi;
    logic [63:0] stream1_lo;
    logic [63:0] stream0_hi;
    logic [63:0] stream0_lo;
  } in_item_t;

  typedef struct packed {
    logic            last_of_run;
    logic            scaled;
    logic [IdxW-1:0] site_index;
    logic [63:0]     out_pair_7;
    logic [63:0]     out_pair_6;
    logic [63:0]     out_pair_5;
    logic [63:0]     out_pair_4;
    logic [63:0]     out_pair_3;
    logic [63:0]     out_pair_2;
    logic [63:0]     out_pair_1;
    logic [63:0]     out_pair_0;
  } out_item_t;

  typedef struct packed {
    logic            scale;
    logic            last;
    logic [IdxW-1:0] idx;
  } site_ctl_t;

  // Exact multiplication of a value below 2^-32 by 2^32.
  function automatic logic [31:0] scale_lane(input logic [31:0] v);
    logic [4:0]  p;
    logic [22:0] man;
    logic [22:0] frac;
    logic [7:0]  ex;
    man  = v[22:0];
    p    = '0;
    for (int b = 0; b < 23; b++) begin
      if (man[b]) begin
        p = 5'(b);
      end
    end
    frac = 23'(man << (5'd23 - p));
    ex   = v[30:23];
    if (ex != 8'd0) begin
      scale_lane = {v[31], ex + 8'd32, man};
    end else if (man == 23'd0) begin
      scale_lane = v;
    end else begin
      scale_lane = {v[31], 8'({3'd0, p} + 8'd10), frac};
    end
  endfunction

endpackage

// File: hdl/likelihood_underflow_rescaler_top.sv
// ----------------------------------------------------------------------------
// Likelihood underflow rescaler
// Rescales a site of 16 single-precision likelihoods by 2^32 on underflow.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   lur_pkg::in_item_t
// out       output     out_valid/out_ready lur_pkg::out_item_t
// cfg       input      cfg_valid/cfg_ready site_count, 24 bits
//
// One site is accepted per cycle unless an output stall fills both stages.
// The input register and result register together form a two-deep pipe.
// Reset clears site_count, the site counter and both valid flags.
// A stalled output holds its result and stops input only when both stages are full.
// ----------------------------------------------------------------------------
`include "likelihood_underflow_rescaler_top_macros.svh"
module likelihood_underflow_rescaler_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  lur_pkg::in_item_t  in_data_i,
  output logic               out_valid,
  input  logic               out_ready,
  output lur_pkg::out_item_t out_data_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data_i
);
  lur_pkg::in_item_t          in_q;
  lur_pkg::site_ctl_t         ctl_q, ctl_d;
  logic                       in_vld_q;
  lur_pkg::out_item_t         res_q, res_d;
  logic                       res_vld_q;
  logic [lur_pkg::IdxW-1:0]   site_count_q;
  logic                       adv, take, real_site, last_site;
  logic [lur_pkg::IdxW-1:0]   idx;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_q && (!res_vld_q || out_ready);
  assign in_ready  = !in_vld_q || adv;
  assign take      = in_valid && in_ready;

  lur_site_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .step_i       (take),
    .site_count_i (site_count_q),
    .real_o       (real_site),
    .last_o       (last_site),
    .idx_o        (idx)
  );

  assign ctl_d = '{scale: real_site, last: last_site, idx: idx};

  lur_scale_datapath u_dp (
    .item_i (in_q),
    .ctl_i  (ctl_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= '0;
      in_vld_q     <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        site_count_q <= cfg_data_i;
      end
      if (in_ready) begin
        in_vld_q <= in_valid;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q  <= in_data_i;
      ctl_q <= ctl_d;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid  = res_vld_q;
  assign out_data_o = res_q;

  `LUR_ASSERT_STABLE(a_stall_hold, clk_i, rst_ni, (out_valid && !out_ready), res_q,
    "result changed while stalled")
  `LUR_ASSERT(a_scale_real, clk_i, rst_ni,
    (out_valid && res_q.scaled) |-> (res_q.site_index < site_count_q),
    "scaled flag on padding site")
  `LUR_ASSERT(a_no_drop, clk_i, rst_ni, (in_vld_q && res_vld_q && !out_ready) |-> !in_ready,
    "input accepted into a full pipe")
endmodule

// File: hdl/lur_site_ctrl.sv
// ----------------------------------------------------------------------------
// Site counter
// Tracks the site index within a run and flags real and last sites.
// ----------------------------------------------------------------------------
`include "likelihood_underflow_rescaler_top_macros.svh"
module lur_site_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [lur_pkg::IdxW-1:0]    site_count_i,
  output logic                        real_o,
  output logic                        last_o,
  output logic [lur_pkg::IdxW-1:0]    idx_o
);
  logic [lur_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic [lur_pkg::IdxW:0]   total;
  logic [lur_pkg::IdxW:0]   next_idx;

  assign total    = {1'b0, site_count_i} + {{lur_pkg::IdxW{1'b0}}, site_count_i[0]};
  assign next_idx = {1'b0, cnt_q} + 25'd1;
  assign last_o   = next_idx >= total;
  assign real_o   = cnt_q < site_count_i;
  assign idx_o    = cnt_q;
  assign cnt_d    = last_o ? '0 : next_idx[lur_pkg::IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  `LUR_ASSERT(a_wrap, clk_i, rst_ni, (step_i && last_o) |=> (cnt_q == '0),
    "counter did not wrap after last site")
  `LUR_ASSERT_STABLE(a_hold, clk_i, rst_ni, !step_i, cnt_q,
    "counter moved without a transaction")
  `LUR_ASSERT(a_real_not_last, clk_i, rst_ni,
    (real_o && (next_idx < {1'b0, site_count_i})) |-> !last_o,
    "last flagged inside the run")
endmodule

// File: hdl/lur_scale_datapath.sv
// ----------------------------------------------------------------------------
// Scaling datapath
// Tests all lanes for underflow; scales a real all-tiny site exactly by 2^32.
// ----------------------------------------------------------------------------
module lur_scale_datapath (
  input  lur_pkg::in_item_t  item_i,
  input  lur_pkg::site_ctl_t ctl_i,
  output lur_pkg::out_item_t res_o
);
  logic [lur_pkg::Lanes-1:0][31:0] lane;
  logic [lur_pkg::Lanes-1:0][31:0] res;
  logic [lur_pkg::Lanes-1:0]       tiny;
  logic                            scale;

  assign lane = item_i;

  always_comb begin
    for (int i = 0; i < lur_pkg::Lanes; i++) begin
      tiny[i] = lane[i][30:0] < lur_pkg::TinyLimit;
    end
  end

  assign scale = (&tiny) && ctl_i.scale;

  always_comb begin
    for (int i = 0; i < lur_pkg::Lanes; i++) begin
      res[i] = scale ? lur_pkg::scale_lane(lane[i]) : lane[i];
    end
  end

  assign res_o = {ctl_i.last, scale, ctl_i.idx, res};
endmodule

// File: tb/sv/likelihood_underflow_rescaler_top_test.sv
// ----------------------------------------------------------------------------
// Likelihood underflow rescaler testbench
// Drives sites of 16 single-precision likelihoods through the rescaler under
// random input gaps and output stalls, across several run lengths, and checks
// every result against an in-bench prediction of the scaling and the run count.
// ----------------------------------------------------------------------------
module likelihood_underflow_rescaler_top_test;

  class site_scoreboard;
    logic [23:0]          run_sites;
    logic [23:0]          next_site;
    lur_pkg::out_item_t   pending[$];
    int                   mismatches;
    int                   checked;
    int                   scaled_seen;

    function new();
      run_sites = '0;
      next_site = '0;
      mismatches = 0;
      checked = 0;
      scaled_seen = 0;
    endfunction

    function logic [31:0] rescale(logic [31:0] v);
      logic [7:0]  ex;
      logic [22:0] man;
      int          top;
      ex = v[30:23];
      man = v[22:0];
      top = 0;
      if (ex != 0) return {v[31], ex + 8'd32, man};
      if (man == 0) return v;
      for (int b = 0; b < 23; b++) if (man[b]) top = b;
      return {v[31], 8'(top + 10), 23'(man << (23 - top))};
    endfunction

    function void note_site(lur_pkg::in_item_t it);
      logic [63:0]        w[8];
      logic [31:0]        lane[16];
      logic [24:0]        total;
      logic               tiny;
      lur_pkg::out_item_t r;
      w = '{it.stream0_lo, it.stream0_hi, it.stream1_lo, it.stream1_hi,
            it.stream2_lo, it.stream2_hi, it.stream3_lo, it.stream3_hi};
      tiny = 1'b1;
      for (int i = 0; i < 16; i++) begin
        lane[i] = i[0] ? w[i / 2][63:32] : w[i / 2][31:0];
        if (lane[i][30:0] >= lur_pkg::TinyLimit) tiny = 1'b0;
      end
      r.scaled = tiny && (next_site < run_sites);
      if (r.scaled) for (int i = 0; i < 16; i++) lane[i] = rescale(lane[i]);
      r.out_pair_0 = {lane[1], lane[0]};
      r.out_pair_1 = {lane[3], lane[2]};
      r.out_pair_2 = {lane[5], lane[4]};
      r.out_pair_3 = {lane[7], lane[6]};
      r.out_pair_4 = {lane[9], lane[8]};
      r.out_pair_5 = {lane[11], lane[10]};
      r.out_pair_6 = {lane[13], lane[12]};
      r.out_pair_7 = {lane[15], lane[14]};
      total = {1'b0, run_sites} + run_sites[0];
      r.site_index = next_site;
      r.last_of_run = ({1'b0, next_site} + 25'd1) >= total;
      next_site = r.last_of_run ? '0 : next_site + 24'd1;
      pending.push_back(r);
    endfunction

    function void check_site(lur_pkg::out_item_t got);
      lur_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.scaled) scaled_seen++;
      if (got !== want) report("result mismatch", want, got);
    endfunction

    function void report(string what, lur_pkg::out_item_t want, lur_pkg::out_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected %h", what, want);
        $display("  actual %h", got);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  lur_pkg::in_item_t  in_data_i;
  logic               out_valid;
  logic               out_ready;
  lur_pkg::out_item_t out_data_o;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [23:0]        cfg_data_i;
  site_scoreboard     sb;
  int                 idle_cycles;
  bit                 stall_enable;
  bit                 timed_out;

  likelihood_underflow_rescaler_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function logic [31:0] tiny_lane();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
      2: return {$urandom_range(0, 1) == 1, 8'd0, 23'd1 << $urandom_range(0, 22)};
      3: return {$urandom_range(0, 1) == 1, 31'h2F7F_FFFF};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 94)), 23'($urandom)};
    endcase
  endfunction

  function logic [31:0] any_lane();
    case ($urandom_range(0, 4))
      0: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 1) * $urandom)};
      1: return {$urandom_range(0, 1) == 1, 31'h2F80_0000};
      default: return $urandom;
    endcase
  endfunction

  // Kind 0: all tiny, 1: tiny but one arbitrary lane, 2: fully random, 3: all lanes all ones.
  function lur_pkg::in_item_t make_site(int kind);
    logic [31:0] lane[16];
    for (int i = 0; i < 16; i++) lane[i] = (kind == 2) ? $urandom : tiny_lane();
    if (kind == 1) lane[$urandom_range(0, 15)] = any_lane();
    if (kind == 3) for (int i = 0; i < 16; i++) lane[i] = '1;
    make_site = {lane[15], lane[14], lane[13], lane[12], lane[11], lane[10],
                 lane[9], lane[8], lane[7], lane[6], lane[5], lane[4],
                 lane[3], lane[2], lane[1], lane[0]};
  endfunction

  // Valid stays high after an acceptance until the next call or a drain lowers it.
  task automatic send_site(lur_pkg::in_item_t it);
    int g;
    g = stall_enable ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_site(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_site_count(logic [23:0] n);
    cfg_valid <= 1'b1;
    cfg_data_i <= n;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.run_sites = n;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) sb.check_site(out_data_o);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (stall_enable)
        out_ready <= (gap_len() == 0);
      else
        out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= 2000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d results outstanding", sb.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [23:0] counts[7];
    sb = new();
    idle_cycles = 0;
    timed_out = 1'b0;
    stall_enable = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data_i = '0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty run after reset, then a short odd run with padding.
    send_site(make_site(0));
    send_site(make_site(3));
    drain();
    write_site_count(24'd3);
    for (int k = 0; k < 4; k++) send_site(make_site(k));
    send_site(make_site(0));
    send_site(make_site(1));
    send_site('0);
    send_site(make_site(0));
    drain();
    // Lowered count in mid-run leaves the counter past the run end.
    write_site_count(24'd6);
    for (int k = 0; k < 4; k++) send_site(make_site(0));
    drain();
    write_site_count(24'd2);
    send_site(make_site(0));
    send_site(make_site(0));
    send_site(make_site(0));
    drain();

    counts = '{24'd1, 24'd7, 24'd16, 24'd33, 24'hFFFFFF, 24'hFFFFFE, 24'd0};
    stall_enable = 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      write_site_count(counts[ph]);
      for (int n = 0; n < 275; n++) begin
        if (ph == 3 && n < 60) stall_enable = 1'b0;
        else stall_enable = 1'b1;
        send_site(make_site($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3)));
      end
      drain();
    end

    drain();
    $display("Checked %0d sites, %0d of them rescaled, across seven run lengths.",
             sb.checked, sb.scaled_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/lur_pkg.sv
hdl/lur_site_ctrl.sv
hdl/lur_scale_datapath.sv
hdl/likelihood_underflow_rescaler_top.sv
tb/sv/likelihood_underflow_rescaler_top_test.sv
